>>> hw/rtl/nmea_gga_sentence_decoder_macros.svh
// Assertion macros shared by the checker of the GGA sentence decoder.
`ifndef NMEA_GGA_SENTENCE_DECODER_MACROS_SVH
`define NMEA_GGA_SENTENCE_DECODER_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled while arst_n is low.
`define NGGA_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("GGA decoder assertion failed");

// Next-cycle implication, clocked on clk and disabled while arst_n is low.
`define NGGA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("GGA decoder assertion failed");

`endif

>>> hw/rtl/ngga_pkg.sv
// Types, constants and helper functions of the GGA sentence decoder.
`default_nettype none

package ngga_pkg;

	typedef enum logic [1:0] {
		PH_BODY   = 2'd0,
		PH_HEX_HI = 2'd1,
		PH_HEX_LO = 2'd2
	} ngga_phase_t;

	localparam logic [1:0] KIND_UNKNOWN = 2'd0;
	localparam logic [1:0] KIND_GGA     = 2'd1;
	localparam logic [1:0] KIND_VTG     = 2'd2;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;

	localparam logic [3:0] FLD_LAT      = 4'd2;
	localparam logic [3:0] FLD_LAT_HEMI = 4'd3;
	localparam logic [3:0] FLD_LON      = 4'd4;
	localparam logic [3:0] FLD_LON_HEMI = 4'd5;
	localparam logic [3:0] FLD_QUALITY  = 4'd6;
	localparam logic [3:0] FLD_AGE      = 4'd13;
	localparam logic [3:0] FLD_MAX      = 4'd15;

	localparam logic [2:0] HDR_LEN          = 3'd5;
	localparam logic [2:0] LAT_WHOLE_DIGITS = 3'd4;
	localparam logic [2:0] LON_WHOLE_DIGITS = 3'd5;
	localparam logic [2:0] FRAC_DIGITS      = 3'd5;
	localparam logic [2:0] DPOS_MAX         = 3'd7;

	localparam logic [2:0] MATCH_GPGGA = 3'b001;
	localparam logic [2:0] MATCH_GPVTG = 3'b010;
	localparam logic [2:0] MATCH_GNGGA = 3'b100;

	localparam logic [39:0] HDR_GPGGA = "GPGGA";
	localparam logic [39:0] HDR_GPVTG = "GPVTG";
	localparam logic [39:0] HDR_GNGGA = "GNGGA";

	typedef struct packed {
		logic        checksum_ok;
		logic [1:0]  sentence_kind;
		logic [13:0] lat_whole;
		logic [16:0] lat_fraction;
		logic [7:0]  lat_hemisphere;
		logic [16:0] lon_whole;
		logic [16:0] lon_fraction;
		logic [7:0]  lon_hemisphere;
		logic [2:0]  fix_quality;
		logic [6:0]  correction_age;
	} ngga_result_t;

	function automatic logic [7:0] hdr_char(input logic [39:0] hdr, input logic [2:0] pos);
		logic [7:0] ch;
		case (pos)
			3'd0: ch = hdr[39:32];
			3'd1: ch = hdr[31:24];
			3'd2: ch = hdr[23:16];
			3'd3: ch = hdr[15:8];
			3'd4: ch = hdr[7:0];
			default: ch = 8'd0;
		endcase
		return ch;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	// Upper bit set means the character is not a hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		if (c inside {[8'h30:8'h39]}) begin
			v = {1'b0, c[3:0]};
		end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			v = {1'b0, c[3:0] + 4'd9};
		end else begin
			v = 5'b10000;
		end
		return v;
	endfunction

	// A decimal digit scaled by ten to the given power, powers nought to four.
	function automatic logic [16:0] scaled_digit(input logic [3:0] d, input logic [2:0] pow);
		logic [16:0] dw;
		logic [16:0] r;
		dw = {13'd0, d};
		case (pow)
			3'd0: r = dw;
			3'd1: r = dw * 17'd10;
			3'd2: r = dw * 17'd100;
			3'd3: r = dw * 17'd1000;
			default: r = dw * 17'd10000;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ngga_core.sv
// Sentence state, field accumulators and result formation of the GGA decoder.
`default_nettype none

module ngga_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic [7:0]          ch,
	output logic                     result_fire,
	output ngga_pkg::ngga_result_t   result
);
	import ngga_pkg::*;

	ngga_phase_t phase_q, phase_d;
	logic        in_sentence_q, in_sentence_d;
	logic [7:0]  xor_q, xor_d;
	logic [3:0]  hex_hi_q, hex_hi_d;
	logic        hex_bad_q, hex_bad_d;
	logic [2:0]  hdr_pos_q, hdr_pos_d;
	logic [2:0]  match_q, match_d;
	logic [3:0]  field_q, field_d;
	logic        dot_q, dot_d;
	logic [2:0]  dpos_q, dpos_d;
	logic [13:0] lat_whole_q, lat_whole_d;
	logic [16:0] lat_frac_q, lat_frac_d;
	logic [16:0] lon_whole_q, lon_whole_d;
	logic [16:0] lon_frac_q, lon_frac_d;
	logic [7:0]  lat_letter_q, lat_letter_d;
	logic [7:0]  lon_letter_q, lon_letter_d;
	logic [2:0]  quality_q, quality_d;
	logic [6:0]  age_q, age_d;

	logic [3:0]  dval;
	logic        dig;
	logic [2:0]  dpos_inc;
	logic [2:0]  lat_pow;
	logic [2:0]  lon_pow;
	logic [2:0]  frac_pow;
	logic [16:0] frac_add;
	logic [16:0] lat_add;
	logic [16:0] age_add;
	logic [4:0]  hv;
	logic [3:0]  hex_lo;
	logic        ok;
	logic [1:0]  kind;
	logic        gga;

	assign dval     = ch[3:0];
	assign dig      = is_digit(ch);
	assign dpos_inc = (dpos_q < DPOS_MAX) ? dpos_q + 3'd1 : dpos_q;
	assign lat_pow  = LAT_WHOLE_DIGITS - 3'd1 - dpos_q;
	assign lon_pow  = LON_WHOLE_DIGITS - 3'd1 - dpos_q;
	assign frac_pow = FRAC_DIGITS - 3'd1 - dpos_q;
	assign frac_add = scaled_digit(dval, frac_pow);
	assign lat_add  = scaled_digit(dval, lat_pow);
	assign age_add  = scaled_digit(dval, 3'd1);

	always_comb begin
		phase_d = phase_q;
		if (step) begin
			if (ch == CH_DOLLAR) begin
				phase_d = PH_BODY;
			end else if (in_sentence_q) begin
				case (phase_q)
					PH_BODY: begin
						if (ch == CH_STAR) begin
							phase_d = PH_HEX_HI;
						end
					end
					PH_HEX_HI: phase_d = PH_HEX_LO;
					PH_HEX_LO: phase_d = PH_BODY;
					default:   phase_d = PH_BODY;
				endcase
			end
		end
	end

	always_comb begin
		in_sentence_d = in_sentence_q;
		xor_d         = xor_q;
		hex_hi_d      = hex_hi_q;
		hex_bad_d     = hex_bad_q;
		hdr_pos_d     = hdr_pos_q;
		match_d       = match_q;
		field_d       = field_q;
		dot_d         = dot_q;
		dpos_d        = dpos_q;
		lat_whole_d   = lat_whole_q;
		lat_frac_d    = lat_frac_q;
		lon_whole_d   = lon_whole_q;
		lon_frac_d    = lon_frac_q;
		lat_letter_d  = lat_letter_q;
		lon_letter_d  = lon_letter_q;
		quality_d     = quality_q;
		age_d         = age_q;
		if (step) begin
			if (ch == CH_DOLLAR) begin
				in_sentence_d = 1'b1;
				xor_d         = 8'd0;
				hex_hi_d      = 4'd0;
				hex_bad_d     = 1'b0;
				hdr_pos_d     = 3'd0;
				match_d       = MATCH_GPGGA | MATCH_GPVTG | MATCH_GNGGA;
				field_d       = 4'd0;
				dot_d         = 1'b0;
				dpos_d        = 3'd0;
				lat_whole_d   = 14'd0;
				lat_frac_d    = 17'd0;
				lon_whole_d   = 17'd0;
				lon_frac_d    = 17'd0;
				lat_letter_d  = 8'd0;
				lon_letter_d  = 8'd0;
				quality_d     = 3'd0;
				age_d         = 7'd0;
			end else if (in_sentence_q) begin
				case (phase_q)
					PH_BODY: begin
						if (ch == CH_STAR) begin
							hex_bad_d = 1'b0;
						end else begin
							xor_d = xor_q ^ ch;
							if (hdr_pos_q < HDR_LEN) begin
								if (ch != hdr_char(HDR_GPGGA, hdr_pos_q)) begin
									match_d[0] = 1'b0;
								end
								if (ch != hdr_char(HDR_GPVTG, hdr_pos_q)) begin
									match_d[1] = 1'b0;
								end
								if (ch != hdr_char(HDR_GNGGA, hdr_pos_q)) begin
									match_d[2] = 1'b0;
								end
								hdr_pos_d = hdr_pos_q + 3'd1;
							end else if (ch == CH_COMMA) begin
								if (field_q < FLD_MAX) begin
									field_d = field_q + 4'd1;
								end
								dot_d  = 1'b0;
								dpos_d = 3'd0;
							end else begin
								case (field_q)
									FLD_LAT: begin
										if (ch == CH_DOT) begin
											if (!dot_q) begin
												dot_d  = 1'b1;
												dpos_d = 3'd0;
											end
										end else if (dig) begin
											if (!dot_q) begin
												if (dpos_q < LAT_WHOLE_DIGITS) begin
													lat_whole_d = lat_whole_q
														+ lat_add[13:0];
												end
											end else if (dpos_q < FRAC_DIGITS) begin
												lat_frac_d = lat_frac_q + frac_add;
											end
											dpos_d = dpos_inc;
										end
									end
									FLD_LAT_HEMI: begin
										if (ch inside {[8'h41:8'h5A]}) begin
											lat_letter_d = ch;
										end
									end
									FLD_LON: begin
										if (ch == CH_DOT) begin
											if (!dot_q) begin
												dot_d  = 1'b1;
												dpos_d = 3'd0;
											end
										end else if (dig) begin
											if (!dot_q) begin
												if (dpos_q < LON_WHOLE_DIGITS) begin
													lon_whole_d = lon_whole_q
														+ scaled_digit(dval, lon_pow);
												end
											end else if (dpos_q < FRAC_DIGITS) begin
												lon_frac_d = lon_frac_q + frac_add;
											end
											dpos_d = dpos_inc;
										end
									end
									FLD_LON_HEMI: begin
										if (ch inside {[8'h41:8'h5A]}) begin
											lon_letter_d = ch;
										end
									end
									FLD_QUALITY: begin
										if (ch inside {[8'h30:8'h35]}) begin
											quality_d = ch[2:0];
										end
									end
									FLD_AGE: begin
										if (dig) begin
											if (dpos_q == 3'd0) begin
												age_d = age_q + age_add[6:0];
											end else if (dpos_q == 3'd1) begin
												age_d = age_q + {3'd0, dval};
											end
											dpos_d = dpos_inc;
										end
									end
									default: begin
									end
								endcase
							end
						end
					end
					PH_HEX_HI: begin
						if (hv[4]) begin
							hex_bad_d = 1'b1;
							hex_hi_d  = 4'd0;
						end else begin
							hex_hi_d = hv[3:0];
						end
					end
					PH_HEX_LO: in_sentence_d = 1'b0;
					default:   in_sentence_d = 1'b0;
				endcase
			end
		end
	end

	always_comb begin
		hv     = hex_value(ch);
		hex_lo = hv[4] ? 4'd0 : hv[3:0];
		ok     = !(hex_bad_q || hv[4]) && ({hex_hi_q, hex_lo} == xor_q);
		kind   = KIND_UNKNOWN;
		if (hdr_pos_q == HDR_LEN) begin
			if ((match_q & (MATCH_GPGGA | MATCH_GNGGA)) != 3'd0) begin
				kind = KIND_GGA;
			end else if ((match_q & MATCH_GPVTG) != 3'd0) begin
				kind = KIND_VTG;
			end
		end
		gga = ok && (kind == KIND_GGA);
		result_fire = step && (ch != CH_DOLLAR) && in_sentence_q && (phase_q == PH_HEX_LO);
		result.checksum_ok    = ok;
		result.sentence_kind  = kind;
		result.lat_whole      = gga ? lat_whole_q  : 14'd0;
		result.lat_fraction   = gga ? lat_frac_q   : 17'd0;
		result.lat_hemisphere = gga ? lat_letter_q : 8'd0;
		result.lon_whole      = gga ? lon_whole_q  : 17'd0;
		result.lon_fraction   = gga ? lon_frac_q   : 17'd0;
		result.lon_hemisphere = gga ? lon_letter_q : 8'd0;
		result.fix_quality    = gga ? quality_q    : 3'd0;
		result.correction_age = gga ? age_q        : 7'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_BODY;
			in_sentence_q <= 1'b0;
			xor_q         <= 8'd0;
			hex_hi_q      <= 4'd0;
			hex_bad_q     <= 1'b0;
			hdr_pos_q     <= 3'd0;
			match_q       <= MATCH_GPGGA | MATCH_GPVTG | MATCH_GNGGA;
			field_q       <= 4'd0;
			dot_q         <= 1'b0;
			dpos_q        <= 3'd0;
			lat_whole_q   <= 14'd0;
			lat_frac_q    <= 17'd0;
			lon_whole_q   <= 17'd0;
			lon_frac_q    <= 17'd0;
			lat_letter_q  <= 8'd0;
			lon_letter_q  <= 8'd0;
			quality_q     <= 3'd0;
			age_q         <= 7'd0;
		end else begin
			phase_q       <= phase_d;
			in_sentence_q <= in_sentence_d;
			xor_q         <= xor_d;
			hex_hi_q      <= hex_hi_d;
			hex_bad_q     <= hex_bad_d;
			hdr_pos_q     <= hdr_pos_d;
			match_q       <= match_d;
			field_q       <= field_d;
			dot_q         <= dot_d;
			dpos_q        <= dpos_d;
			lat_whole_q   <= lat_whole_d;
			lat_frac_q    <= lat_frac_d;
			lon_whole_q   <= lon_whole_d;
			lon_frac_q    <= lon_frac_d;
			lat_letter_q  <= lat_letter_d;
			lon_letter_q  <= lon_letter_d;
			quality_q     <= quality_d;
			age_q         <= age_d;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/ngga_out_reg.sv
// Result register of the GGA decoder, holding one beat until it is taken.
`default_nettype none

module ngga_out_reg (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   load,
	input  wire ngga_pkg::ngga_result_t result_d,
	input  wire logic                   result_ready,
	output logic                        result_valid,
	output ngga_pkg::ngga_result_t      result_q,
	output logic                        advance
);
	import ngga_pkg::*;

	logic valid_q;

	assign advance      = !valid_q || result_ready;
	assign result_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load) begin
			result_q <= result_d;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/nmea_gga_sentence_decoder.sv
// Top level of the GGA sentence decoder: character register, parser core and result register.
//
//   Channel  Direction  Handshake                   Payload
//   char     in         char_valid / char_ready     char_in
//   result   out        result_valid / result_ready checksum_ok .. correction_age
//
// One character is taken every cycle while the result side is not stalled.
// A character is registered, then parsed once the result side is not stalled; a result
// beat is registered when the second checksum digit is parsed, and is then shown as valid.
// A held result beat stalls the parser, and char_ready then drops once the
// character register is full. Reset clears all control and parser state at once.
`default_nettype none

module nmea_gga_sentence_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        char_valid,
	output logic             char_ready,
	input  wire logic [7:0]  char_in,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic             checksum_ok,
	output logic [1:0]       sentence_kind,
	output logic [13:0]      lat_whole,
	output logic [16:0]      lat_fraction,
	output logic [7:0]       lat_hemisphere,
	output logic [16:0]      lon_whole,
	output logic [16:0]      lon_fraction,
	output logic [7:0]       lon_hemisphere,
	output logic [2:0]       fix_quality,
	output logic [6:0]       correction_age
);
	import ngga_pkg::*;

	logic         char_valid_s1;
	logic [7:0]   char_s1;
	logic         advance;
	logic         step;
	logic         fire;
	ngga_result_t res_d;
	ngga_result_t res_q;

	assign char_ready = !char_valid_s1 || advance;
	assign step       = char_valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_s1 <= 1'b0;
		end else if (char_ready) begin
			char_valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			char_s1 <= char_in;
		end
	end

	ngga_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.ch          (char_s1),
		.result_fire (fire),
		.result      (res_d)
	);

	ngga_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (fire),
		.result_d     (res_d),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result_q     (res_q),
		.advance      (advance)
	);

	assign checksum_ok    = res_q.checksum_ok;
	assign sentence_kind  = res_q.sentence_kind;
	assign lat_whole      = res_q.lat_whole;
	assign lat_fraction   = res_q.lat_fraction;
	assign lat_hemisphere = res_q.lat_hemisphere;
	assign lon_whole      = res_q.lon_whole;
	assign lon_fraction   = res_q.lon_fraction;
	assign lon_hemisphere = res_q.lon_hemisphere;
	assign fix_quality    = res_q.fix_quality;
	assign correction_age = res_q.correction_age;

endmodule

`default_nettype wire

>>> hw/rtl/ngga_checker.sv
// Port-level assertion checker of the GGA decoder and its binding to the top level.
`default_nettype none

`include "nmea_gga_sentence_decoder_macros.svh"

module ngga_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        char_valid,
	input wire logic        char_ready,
	input wire logic [7:0]  char_in,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire logic        checksum_ok,
	input wire logic [1:0]  sentence_kind,
	input wire logic [13:0] lat_whole,
	input wire logic [16:0] lat_fraction,
	input wire logic [7:0]  lat_hemisphere,
	input wire logic [16:0] lon_whole,
	input wire logic [16:0] lon_fraction,
	input wire logic [7:0]  lon_hemisphere,
	input wire logic [2:0]  fix_quality,
	input wire logic [6:0]  correction_age
);
	import ngga_pkg::*;

	logic stall;
	logic gga_zero;
	logic not_gga;

	assign stall    = result_valid && !result_ready;
	assign not_gga  = !checksum_ok || (sentence_kind != KIND_GGA);
	assign gga_zero = (lat_whole == 14'd0) && (lat_fraction == 17'd0)
		&& (lat_hemisphere == 8'd0) && (lon_whole == 17'd0)
		&& (lon_fraction == 17'd0) && (lon_hemisphere == 8'd0)
		&& (fix_quality == 3'd0) && (correction_age == 7'd0)
		&& (char_in == char_in);

	`NGGA_ASSERT_NEXT(a_result_held, stall, result_valid)
	`NGGA_ASSERT_NEXT(a_result_stable, stall, $stable(checksum_ok) && $stable(sentence_kind) && $stable(lat_whole) && $stable(lon_whole))
	`NGGA_ASSERT_IMPL(a_result_follows_char, $rose(result_valid), $past(char_valid && char_ready, 2))
	`NGGA_ASSERT_IMPL(a_fields_gated, result_valid && not_gga, gga_zero)
	`NGGA_ASSERT_IMPL(a_value_ranges, result_valid, (fix_quality <= 3'd5) && (correction_age <= 7'd99) && (sentence_kind != 2'd3))

endmodule

bind nmea_gga_sentence_decoder ngga_checker u_ngga_checker (.*);

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench of the GGA sentence decoder: NMEA character streams in, decoded beats checked.
module tb;
	import ngga_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 12;
	localparam int MAX_GAP       = 6;
	localparam int LONG_HOLD     = 400;
	localparam int RANDOM_CHARS  = 240;
	localparam int MAX_REPORTS   = 200;

	localparam logic [7:0] CH_ZERO    = "0";
	localparam logic [7:0] CH_FIVE    = "5";
	localparam logic [7:0] CH_NINE    = "9";
	localparam logic [7:0] CH_UPPER_A = "A";
	localparam logic [7:0] CH_UPPER_F = "F";
	localparam logic [7:0] CH_UPPER_Z = "Z";
	localparam logic [7:0] CH_LOWER_A = "a";
	localparam logic [7:0] CH_LOWER_F = "f";

	typedef enum int {
		CS_GOOD,
		CS_UPPER,
		CS_LOWER,
		CS_WRONG,
		CS_BAD_HI,
		CS_BAD_LO,
		CS_OPEN
	} tail_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        char_valid = 1'b0;
	logic        char_ready;
	logic [7:0]  char_in = 8'd0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic        checksum_ok;
	logic [1:0]  sentence_kind;
	logic [13:0] lat_whole;
	logic [16:0] lat_fraction;
	logic [7:0]  lat_hemisphere;
	logic [16:0] lon_whole;
	logic [16:0] lon_fraction;
	logic [7:0]  lon_hemisphere;
	logic [2:0]  fix_quality;
	logic [6:0]  correction_age;

	nmea_gga_sentence_decoder u_top (.*);

	// Parser state of the behavioural model.
	logic        sentence_open;
	ngga_phase_t phase;
	logic [7:0]  sum_acc;
	logic [3:0]  hex_hi;
	logic        hex_bad;
	int          hdr_idx;
	logic [2:0]  hdr_hits;
	logic [3:0]  field_idx;
	logic        after_dot;
	int          digit_idx;
	int unsigned lat_w, lat_f, lon_w, lon_f, age;
	logic [7:0]  lat_hemi, lon_hemi;
	logic [2:0]  quality;

	ngga_result_t expected_fixes[$];
	logic [7:0]   sentence_buf[$];

	int mismatches = 0;
	int parsed_chars = 0;
	int cycle_count = 0;
	int hold_cycles = 0;
	bit no_idle = 1'b0;

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic bit is_numeral(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic int hex_nibble(input logic [7:0] c);
		if (is_numeral(c))
			return c - CH_ZERO;
		if (c >= CH_UPPER_A && c <= CH_UPPER_F)
			return c - CH_UPPER_A + 10;
		if (c >= CH_LOWER_A && c <= CH_LOWER_F)
			return c - CH_LOWER_A + 10;
		return -1;
	endfunction

	function automatic int unsigned place_value(input int pos, input int ndigits);
		int unsigned w;
		w = 1;
		if (pos >= ndigits)
			return 0;
		repeat (ndigits - 1 - pos) w = w * 10;
		return w;
	endfunction

	function automatic void clear_parser();
		sentence_open = 1'b0;
		phase = PH_BODY;
		sum_acc = 8'd0;
		hex_hi = 4'd0;
		hex_bad = 1'b0;
		hdr_idx = 0;
		hdr_hits = MATCH_GPGGA | MATCH_GPVTG | MATCH_GNGGA;
		field_idx = 4'd0;
		after_dot = 1'b0;
		digit_idx = 0;
		lat_w = 0;
		lat_f = 0;
		lon_w = 0;
		lon_f = 0;
		age = 0;
		lat_hemi = 8'd0;
		lon_hemi = 8'd0;
		quality = 3'd0;
	endfunction

	function automatic void take_coord_char(input logic [7:0] c, input int nwhole,
			inout int unsigned whole, inout int unsigned frac);
		if (c == CH_DOT) begin
			if (!after_dot) begin
				after_dot = 1'b1;
				digit_idx = 0;
			end
			return;
		end
		if (!is_numeral(c))
			return;
		if (!after_dot)
			whole += (c - CH_ZERO) * place_value(digit_idx, nwhole);
		else
			frac += (c - CH_ZERO) * place_value(digit_idx, FRAC_DIGITS);
		if (digit_idx < DPOS_MAX)
			digit_idx++;
	endfunction

	function automatic void take_body_char(input logic [7:0] c);
		sum_acc ^= c;
		if (hdr_idx < HDR_LEN) begin
			if (c != HDR_GPGGA[8 * (4 - hdr_idx) +: 8])
				hdr_hits &= ~MATCH_GPGGA;
			if (c != HDR_GPVTG[8 * (4 - hdr_idx) +: 8])
				hdr_hits &= ~MATCH_GPVTG;
			if (c != HDR_GNGGA[8 * (4 - hdr_idx) +: 8])
				hdr_hits &= ~MATCH_GNGGA;
			hdr_idx++;
			return;
		end
		if (c == CH_COMMA) begin
			if (field_idx < FLD_MAX)
				field_idx++;
			after_dot = 1'b0;
			digit_idx = 0;
			return;
		end
		case (field_idx)
			FLD_LAT: take_coord_char(c, LAT_WHOLE_DIGITS, lat_w, lat_f);
			FLD_LAT_HEMI: if (c >= CH_UPPER_A && c <= CH_UPPER_Z) lat_hemi = c;
			FLD_LON: take_coord_char(c, LON_WHOLE_DIGITS, lon_w, lon_f);
			FLD_LON_HEMI: if (c >= CH_UPPER_A && c <= CH_UPPER_Z) lon_hemi = c;
			FLD_QUALITY: if (c >= CH_ZERO && c <= CH_FIVE) quality = 3'(c - CH_ZERO);
			FLD_AGE: begin
				if (is_numeral(c)) begin
					if (digit_idx == 0)
						age += (c - CH_ZERO) * 10;
					else if (digit_idx == 1)
						age += c - CH_ZERO;
					if (digit_idx < DPOS_MAX)
						digit_idx++;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void decode_char(input logic [7:0] c);
		ngga_result_t fix;
		int           nib;
		logic [1:0]   kind;
		logic         ok;
		if (c == CH_DOLLAR) begin
			clear_parser();
			sentence_open = 1'b1;
			parsed_chars++;
			return;
		end
		if (!sentence_open)
			return;
		parsed_chars++;
		case (phase)
			PH_BODY: begin
				if (c == CH_STAR) begin
					phase = PH_HEX_HI;
					hex_bad = 1'b0;
				end else begin
					take_body_char(c);
				end
			end
			PH_HEX_HI: begin
				nib = hex_nibble(c);
				if (nib < 0) begin
					hex_bad = 1'b1;
					hex_hi = 4'd0;
				end else begin
					hex_hi = nib[3:0];
				end
				phase = PH_HEX_LO;
			end
			default: begin
				nib = hex_nibble(c);
				if (nib < 0) begin
					hex_bad = 1'b1;
					nib = 0;
				end
				ok = !hex_bad && ({hex_hi, nib[3:0]} == sum_acc);
				kind = KIND_UNKNOWN;
				if (hdr_idx == HDR_LEN) begin
					if ((hdr_hits & (MATCH_GPGGA | MATCH_GNGGA)) != 3'd0)
						kind = KIND_GGA;
					else if ((hdr_hits & MATCH_GPVTG) != 3'd0)
						kind = KIND_VTG;
				end
				fix = '0;
				fix.checksum_ok = ok;
				fix.sentence_kind = kind;
				if (ok && kind == KIND_GGA) begin
					fix.lat_whole = lat_w[13:0];
					fix.lat_fraction = lat_f[16:0];
					fix.lat_hemisphere = lat_hemi;
					fix.lon_whole = lon_w[16:0];
					fix.lon_fraction = lon_f[16:0];
					fix.lon_hemisphere = lon_hemi;
					fix.fix_quality = quality;
					fix.correction_age = age[6:0];
				end
				expected_fixes.push_back(fix);
				sentence_open = 1'b0;
				phase = PH_BODY;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	task automatic check_fix();
		ngga_result_t want;
		if (expected_fixes.size() == 0) begin
			report_mismatch("result beat with no sentence pending");
			return;
		end
		want = expected_fixes.pop_front();
		compare_field("checksum_ok", checksum_ok, want.checksum_ok);
		compare_field("sentence_kind", sentence_kind, want.sentence_kind);
		compare_field("lat_whole", lat_whole, want.lat_whole);
		compare_field("lat_fraction", lat_fraction, want.lat_fraction);
		compare_field("lat_hemisphere", lat_hemisphere, want.lat_hemisphere);
		compare_field("lon_whole", lon_whole, want.lon_whole);
		compare_field("lon_fraction", lon_fraction, want.lon_fraction);
		compare_field("lon_hemisphere", lon_hemisphere, want.lon_hemisphere);
		compare_field("fix_quality", fix_quality, want.fix_quality);
		compare_field("correction_age", correction_age, want.correction_age);
	endtask

	// Result side: a random stall before each beat, or a long hold when one is requested.
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_cycles > 0) begin
				result_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
				if (stall > 0) begin
					result_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid && hold_cycles == 0) @(posedge clk);
			if (result_valid)
				check_fix();
		end
	end

	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_in <= c;
		@(posedge clk);
		while (!char_ready) @(posedge clk);
		decode_char(c);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	function automatic logic [7:0] hex_digit(input logic [3:0] n, input bit upper);
		if (n < 4'd10)
			return CH_ZERO + 8'(n);
		return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (hex_nibble(c) >= 0 || c == CH_DOLLAR);
		return c;
	endfunction

	function automatic logic [7:0] junk_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_DOLLAR || c == CH_STAR || c == CH_COMMA || c == CH_DOT || is_numeral(c));
		return c;
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			sentence_buf.push_back(s[i]);
	endtask

	// Sends the buffered body framed by the start character, and the checksum in the given form (none for CS_OPEN).
	task automatic send_sentence(input tail_t tail);
		logic [7:0] sum;
		bit         upper;
		sum = 8'd0;
		foreach (sentence_buf[i])
			sum ^= sentence_buf[i];
		upper = (tail == CS_UPPER) ? 1'b1 : (tail == CS_LOWER) ? 1'b0 : 1'($urandom_range(0, 1));
		send_char(CH_DOLLAR);
		foreach (sentence_buf[i])
			send_char(sentence_buf[i]);
		sentence_buf.delete();
		if (tail == CS_WRONG)
			sum ^= 8'($urandom_range(1, 255));
		case (tail)
			CS_OPEN: ;
			CS_BAD_HI: begin
				send_char(CH_STAR);
				send_char(non_hex_char());
				send_char(hex_digit(sum[3:0], upper));
			end
			CS_BAD_LO: begin
				send_char(CH_STAR);
				send_char(hex_digit(sum[7:4], upper));
				send_char(non_hex_char());
			end
			default: begin
				send_char(CH_STAR);
				send_char(hex_digit(sum[7:4], upper));
				send_char(hex_digit(sum[3:0], upper));
			end
		endcase
	endtask

	task automatic add_digits(input int n);
		repeat (n) sentence_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic add_coord(input int nwhole);
		int nw;
		int nf;
		if ($urandom_range(0, 9) == 0)
			return;
		nw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, nwhole + 2) : nwhole;
		nf = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : FRAC_DIGITS;
		add_digits(nw);
		if ($urandom_range(0, 7) == 0)
			sentence_buf.push_back(junk_char());
		if ($urandom_range(0, 7) != 0) begin
			sentence_buf.push_back(CH_DOT);
			add_digits(nf);
			if ($urandom_range(0, 9) == 0) begin
				sentence_buf.push_back(CH_DOT);
				add_digits(2);
			end
		end
	endtask

	task automatic add_hemisphere(input logic [7:0] a, input logic [7:0] b);
		case ($urandom_range(0, 7))
			0: ;
			1: sentence_buf.push_back(CH_UPPER_A + 8'($urandom_range(0, 25)));
			2: sentence_buf.push_back(junk_char());
			3: begin
				sentence_buf.push_back(a);
				sentence_buf.push_back(b);
			end
			4, 5: sentence_buf.push_back(a);
			default: sentence_buf.push_back(b);
		endcase
	endtask

	task automatic add_random_gga();
		if ($urandom_range(0, 1) == 0)
			add_text("GPGGA,");
		else
			add_text("GNGGA,");
		add_digits(6);
		sentence_buf.push_back(CH_DOT);
		add_digits(2);
		sentence_buf.push_back(CH_COMMA);
		add_coord(LAT_WHOLE_DIGITS);
		sentence_buf.push_back(CH_COMMA);
		add_hemisphere("N", "S");
		sentence_buf.push_back(CH_COMMA);
		add_coord(LON_WHOLE_DIGITS);
		sentence_buf.push_back(CH_COMMA);
		add_hemisphere("E", "W");
		sentence_buf.push_back(CH_COMMA);
		case ($urandom_range(0, 5))
			0: ;
			1: sentence_buf.push_back(junk_char());
			2: add_digits(2);
			default: add_digits(1);
		endcase
		repeat (6) begin
			sentence_buf.push_back(CH_COMMA);
			add_digits($urandom_range(0, 3));
		end
		sentence_buf.push_back(CH_COMMA);
		case ($urandom_range(0, 4))
			0: ;
			1: begin
				add_digits(1);
				sentence_buf.push_back(junk_char());
				add_digits(1);
			end
			2: add_digits(3);
			default: add_digits(2);
		endcase
		sentence_buf.push_back(CH_COMMA);
		add_digits($urandom_range(0, 4));
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 6)) begin
				sentence_buf.push_back(CH_COMMA);
				add_digits(1);
			end
		end
	endtask

	task automatic add_random_other();
		case ($urandom_range(0, 5))
			0: add_text("GNVTG");
			1: add_text("GPGGV");
			2: repeat ($urandom_range(0, 7)) sentence_buf.push_back(junk_char());
			3: repeat ($urandom_range(0, 7))
				sentence_buf.push_back(CH_UPPER_A + 8'($urandom_range(0, 25)));
			default: add_text("GPVTG");
		endcase
		repeat ($urandom_range(0, 8)) begin
			sentence_buf.push_back(CH_COMMA);
			add_digits($urandom_range(0, 4));
		end
	endtask

	function automatic tail_t random_tail();
		case ($urandom_range(0, 19))
			0: return CS_WRONG;
			1: return CS_BAD_HI;
			2: return CS_BAD_LO;
			3: return CS_OPEN;
			default: return CS_GOOD;
		endcase
	endfunction

	task automatic test_sentence_kinds();
		add_text("GPGGA");
		send_sentence(CS_UPPER);
		add_text("GNGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,");
		send_sentence(CS_LOWER);
		add_text("GPVTG,054.7,T,034.4,M,005.5,N,010.2,K");
		send_sentence(CS_UPPER);
		add_text("GPGGB,1,2");
		send_sentence(CS_GOOD);
		add_text("GP");
		send_sentence(CS_GOOD);
		send_sentence(CS_GOOD);
		add_text("G,GGA,,1234.5,N");
		send_sentence(CS_GOOD);
	endtask

	task automatic test_field_extremes();
		add_text("GPGGA,235959.99,9999.99999,S,99999.99999,W,5,12,99.9,9999.9,M,-99.9,M,99,1023");
		send_sentence(CS_UPPER);
		add_text("GNGGA,000000.00,0000.00000,N,00000.00000,E,0,00,0.0,0.0,M,0.0,M,00,0000");
		send_sentence(CS_LOWER);
		add_text("GPGGA,,,Z,,A,3,,,,,,,,");
		send_sentence(CS_GOOD);
	endtask

	task automatic test_malformed_fields();
		add_text("GPGGA,1,123456.1234567,ns,12.34.56,WE,3x5,,,,,,,9x87,1,,,,,,,,,7");
		send_sentence(CS_GOOD);
		add_text("GPGGA,,4a8b0c7.0x3,Nn,1.2.3.4.5,w,9,,,,,,,5");
		send_sentence(CS_GOOD);
		add_text("GNGGA,,1234.56789,N,12345.67890,E,8,,,,,,,123");
		send_sentence(CS_GOOD);
		add_text("GPGGA,,,,,,,,,,,,,,,,,,,,5.5,N");
		send_sentence(CS_GOOD);
	endtask

	task automatic test_checksum_forms();
		tail_t tails[5];
		tails = '{CS_UPPER, CS_LOWER, CS_WRONG, CS_BAD_HI, CS_BAD_LO};
		foreach (tails[i]) begin
			add_text("GPGGA,092750,4916.45,N,12311.12,W,2,,,,,,,12");
			send_sentence(tails[i]);
		end
		send_text("$GPGGA*Gz");
	endtask

	task automatic test_restart_and_noise();
		send_char(8'h00);
		send_char(8'hFF);
		send_char(CH_STAR);
		send_char(CH_COMMA);
		send_text("12.5N");
		send_text("$GPGGA,1,5000.0");
		add_text("GPGGA,1,2500.0,N");
		send_sentence(CS_GOOD);
		send_text("xyz*12");
		send_text("$GPGGA*");
		add_text("GNGGA,,1111");
		send_sentence(CS_GOOD);
		send_text("$GPVTG*4");
		add_text("GPVTG,1");
		send_sentence(CS_GOOD);
	endtask

	// Holds the result side off while whole sentences stream in, so that the block backs up.
	task automatic test_backpressure();
		hold_cycles = LONG_HOLD;
		no_idle = 1'b1;
		repeat (4) begin
			add_random_gga();
			send_sentence(CS_GOOD);
		end
		no_idle = 1'b0;
	endtask

	task automatic test_random_stream();
		int first_chars;
		int pick;
		first_chars = parsed_chars;
		while (parsed_chars < first_chars + RANDOM_CHARS) begin
			if ($urandom_range(0, 9) == 0)
				no_idle = !no_idle;
			pick = $urandom_range(0, 19);
			if (pick == 19) begin
				repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
			end else begin
				if (pick < 14)
					add_random_gga();
				else
					add_random_other();
				if ($urandom_range(0, 9) == 0 && sentence_buf.size() > 0)
					sentence_buf[$urandom_range(0, sentence_buf.size() - 1)] =
						8'($urandom_range(0, 255));
				send_sentence(random_tail());
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		clear_parser();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_sentence_kinds();
		test_field_extremes();
		test_malformed_fields();
		test_checksum_forms();
		test_restart_and_noise();
		test_backpressure();
		test_random_stream();
		char_valid <= 1'b0;
		while (expected_fixes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
